[design/u8d_pkg.sv]
`timescale 1ns / 1ps
package u8d_pkg;

	localparam int CODE_W = 21;
	localparam int USED_W = 3;

	localparam logic [2:0] USED_ONE  = 3'd1;
	localparam logic [2:0] SEQ_NONE  = 3'd0;
	localparam logic [2:0] SEQ_LEN_2 = 3'd2;
	localparam logic [2:0] SEQ_LEN_3 = 3'd3;
	localparam logic [2:0] SEQ_LEN_4 = 3'd4;

	// one accepted byte, classified: pre zeros, optional middle word, post zeros
	typedef struct packed {
		logic [1:0]        pre_cnt;
		logic              has_mid;
		logic [CODE_W-1:0] mid_code;
		logic [USED_W-1:0] mid_used;
		logic [1:0]        post_cnt;
	} item_t;

endpackage

[design/u8d_fifo.sv]
`timescale 1ns / 1ps
module u8d_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  u8d_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output u8d_pkg::item_t head_item,
	output logic           empty
);

	u8d_pkg::item_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;

	assign full      = cnt_q == 2'd2;
	assign empty     = cnt_q == 2'd0;
	assign head_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("queue count out of range");

endmodule

[design/u8d_front.sv]
`timescale 1ns / 1ps
module u8d_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [7:0]     text_byte,
	input  logic           end_of_text,
	output logic           push,
	output u8d_pkg::item_t item
);

	logic [u8d_pkg::CODE_W-1:0] partial_q, partial_n, shifted;
	logic [2:0]                 seq_len_q, seq_len_n;
	logic [1:0]                 seen_q, seen_n;
	logic [2:0]                 seen_inc;
	logic                       pend, cont;

	always_comb begin
		item      = '0;
		partial_n = partial_q;
		seq_len_n = seq_len_q;
		seen_n    = seen_q;
		pend      = seq_len_q != u8d_pkg::SEQ_NONE;
		cont      = text_byte[7:6] == 2'b10;
		shifted   = {partial_q[u8d_pkg::CODE_W-7:0], text_byte[5:0]};
		seen_inc  = {1'b0, seen_q} + 3'd1;
		if (pend && cont) begin
			partial_n = shifted;
			seen_n    = seen_inc[1:0];
			if (seen_inc >= seq_len_q) begin
				item.has_mid  = 1'b1;
				item.mid_code = shifted;
				item.mid_used = seq_len_q;
				partial_n     = '0;
				seq_len_n     = u8d_pkg::SEQ_NONE;
				seen_n        = 2'd0;
			end else if (end_of_text) begin
				item.post_cnt = seen_inc[1:0];
				partial_n     = '0;
				seq_len_n     = u8d_pkg::SEQ_NONE;
				seen_n        = 2'd0;
			end
		end else begin
			if (pend) begin
				item.pre_cnt = seen_q;
			end
			partial_n = '0;
			seq_len_n = u8d_pkg::SEQ_NONE;
			seen_n    = 2'd0;
			priority if (!text_byte[7]) begin
				item.has_mid  = 1'b1;
				item.mid_code = {13'd0, text_byte};
				item.mid_used = u8d_pkg::USED_ONE;
			end else if (text_byte[7:5] == 3'b110) begin
				partial_n = {16'd0, text_byte[4:0]};
				seq_len_n = u8d_pkg::SEQ_LEN_2;
				seen_n    = 2'd1;
			end else if (text_byte[7:4] == 4'b1110) begin
				partial_n = {17'd0, text_byte[3:0]};
				seq_len_n = u8d_pkg::SEQ_LEN_3;
				seen_n    = 2'd1;
			end else if (text_byte[7:3] == 5'b11110) begin
				partial_n = {18'd0, text_byte[2:0]};
				seq_len_n = u8d_pkg::SEQ_LEN_4;
				seen_n    = 2'd1;
			end else begin
				item.has_mid  = 1'b1;
				item.mid_code = '0;
				item.mid_used = u8d_pkg::USED_ONE;
			end
			if (end_of_text && seq_len_n != u8d_pkg::SEQ_NONE) begin
				item.post_cnt = 2'd1;
				partial_n     = '0;
				seq_len_n     = u8d_pkg::SEQ_NONE;
				seen_n        = 2'd0;
			end
		end
	end

	assign push = accept && (item.pre_cnt != 2'd0 || item.has_mid || item.post_cnt != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			seq_len_q <= u8d_pkg::SEQ_NONE;
			seen_q    <= 2'd0;
		end else if (accept) begin
			partial_q <= partial_n;
			seq_len_q <= seq_len_n;
			seen_q    <= seen_n;
		end
	end

	a_seen_in_seq: assert property (@(posedge clk) disable iff (!arst_n)
		seq_len_q != u8d_pkg::SEQ_NONE |-> seen_q != 2'd0 && {1'b0, seen_q} < seq_len_q)
		else $error("byte count outside pending sequence");

	a_ascii_push: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !text_byte[7] |-> push && item.has_mid)
		else $error("ascii byte produced no word");

endmodule

[design/u8d_back.sv]
`timescale 1ns / 1ps
module u8d_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  u8d_pkg::item_t             head_item,
	input  logic                       empty,
	output logic                       pop,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [u8d_pkg::CODE_W-1:0] code_point,
	output logic [u8d_pkg::USED_W-1:0] bytes_used,
	output logic                       run_last
);

	logic [1:0]                 idx_q;
	logic                       m_tvalid_q;
	logic [u8d_pkg::CODE_W-1:0] code_q;
	logic [u8d_pkg::USED_W-1:0] used_q;
	logic                       last_q;
	logic [2:0]                 total;
	logic                       load, is_mid, is_last;

	assign total   = {1'b0, head_item.pre_cnt} + {2'd0, head_item.has_mid}
	               + {1'b0, head_item.post_cnt};
	assign load    = !empty && (!m_tvalid_q || m_tready);
	assign is_mid  = head_item.has_mid && idx_q == head_item.pre_cnt;
	assign is_last = {1'b0, idx_q} == total - 3'd1;
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			idx_q      <= 2'd0;
		end else begin
			if (load) begin
				m_tvalid_q <= 1'b1;
				idx_q      <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_q <= is_mid ? head_item.mid_code : '0;
			used_q <= is_mid ? head_item.mid_used : u8d_pkg::USED_ONE;
			last_q <= is_last;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign code_point = code_q;
	assign bytes_used = used_q;
	assign run_last   = last_q;

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> {1'b0, idx_q} < total)
		else $error("expansion index past item");

	a_single_byte_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && used_q == u8d_pkg::USED_ONE |-> code_q < 21'd128)
		else $error("single byte word above ascii");

endmodule

[design/utf8_stream_decoder.sv]
`timescale 1ns / 1ps
// Byte-serial UTF-8 decoder. Takes one text byte per cycle while s_tready is high
// (tlast marks the final byte of a text) and returns code points with the count of
// bytes each consumed; malformed bytes give code 0. A byte causes zero to four
// output words, tlast set on its final one. The front end classifies and accepts
// a byte every cycle while its two-entry queue has room; the output stage sends
// one word per cycle while m_tready is high, so a byte causing k words holds the
// output until all k are sent; a run of such bytes throttles input via the queue.
module utf8_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_byte
	input  logic        s_tlast,   // end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] bytes_used
	output logic        m_tlast    // run_last
);

	u8d_pkg::item_t             push_item, head_item;
	logic                       push, pop, full, empty, accept;
	logic [u8d_pkg::CODE_W-1:0] code_point;
	logic [u8d_pkg::USED_W-1:0] bytes_used;

	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	u8d_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.text_byte   (s_tdata),
		.end_of_text (s_tlast),
		.push        (push),
		.item        (push_item)
	);

	u8d_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.head_item (head_item),
		.empty     (empty)
	);

	u8d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_item  (head_item),
		.empty      (empty),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.code_point (code_point),
		.bytes_used (bytes_used),
		.run_last   (m_tlast)
	);

	assign m_tdata = {bytes_used, code_point};

endmodule
